FILE: sv/b64d_pkg.sv
// Package for the Base64 stream decoder: result codes, queue record and the alphabet lookup.
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLEAN = 2'd1,
      KIND_TRUNC = 2'd2
   } kind_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   // One queue record: either a decoded group of one to three bytes or an end marker.
   typedef struct packed {
      logic        is_end;
      kind_type    end_kind;
      logic [23:0] bytes;
      logic [1:0]  nbytes;
   } entry_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else if (c == CHAR_PAD) begin
         s.value = '0;
      end else begin
         s.hit = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: sv/b64d_if.sv
// Channel interfaces of the decoder: character request channel and decoded result channel.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] char_in;

   modport source (output valid, output cmd, output char_in, input ready);
   modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       last;

   modport source (output valid, output out_byte, output kind, output last, input ready);
   modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: sv/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: front end, record queue and byte emitter.
//
// Accepts one transaction per cycle on req_if: a text character (cmd 0) or an
// end-of-stream marker (cmd 1). Base64 characters and '=' are collected in
// groups of four; bytes outside that set are dropped. Each closed group is
// queued as one record, and the emitter sends its one to three data bytes on
// rsp_if at one transaction per cycle, last set on the final byte. A group
// padded in third or fourth place ends the stream and later characters are
// ignored until the end marker, which gives a single transaction with kind
// clean or truncated and then clears the group state. Since four characters
// make at most three bytes, the emitter keeps pace with one character per
// cycle; the input stalls only when rsp_if backpressure fills the four-record
// queue. The record of the character that closes a group (or of the end marker)
// is written to the queue when it is accepted and passes from there to the
// output register.
module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_if,
   b64d_rsp_if.source  rsp_if
);
   import b64d_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;
   entry_type head;

   // Classify characters and close groups.
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple group closing from byte emission.
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // Emit bytes and end reports, one result transaction per cycle while rsp_if is ready.
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: sv/b64d_front.sv
// Front end: accepts characters, tracks the current group and pushes group and end records.
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   b64d_req_if.sink            req_if,
   input  logic                queue_full,
   output logic                push,
   output b64d_pkg::entry_type push_entry
);
   import b64d_pkg::*;

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  count_ff, count_in;
   logic        third_pad_ff, third_pad_in;
   logic        finished_ff, finished_in;

   logic        accept;
   logic        is_pad;
   sextet_type  sx;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign sx           = sextet_of(req_if.char_in);
   assign is_pad       = (req_if.char_in == CHAR_PAD);

   always_comb begin
      acc_in       = acc_ff;
      count_in     = count_ff;
      third_pad_in = third_pad_ff;
      finished_in  = finished_ff;
      push         = 1'b0;
      push_entry.is_end   = 1'b0;
      push_entry.end_kind = KIND_CLEAN;
      push_entry.bytes    = {acc_ff, sx.value};
      push_entry.nbytes   = 2'd3;
      if (accept) begin
         if (req_if.cmd) begin
            push                = 1'b1;
            push_entry.is_end   = 1'b1;
            push_entry.end_kind = (count_ff != 2'd0 && !finished_ff) ? KIND_TRUNC : KIND_CLEAN;
            acc_in       = '0;
            count_in     = '0;
            third_pad_in = 1'b0;
            finished_in  = 1'b0;
         end else if (!finished_ff && sx.hit) begin
            if (count_ff != 2'd3) begin
               if (count_ff == 2'd2 && is_pad) begin
                  third_pad_in = 1'b1;
               end
               acc_in   = {acc_ff[11:0], sx.value};
               count_in = count_ff + 2'd1;
            end else begin
               // Fourth symbol closes the group; padding shortens it and ends the stream.
               push = 1'b1;
               if (third_pad_ff) begin
                  push_entry.nbytes = 2'd1;
               end else if (is_pad) begin
                  push_entry.nbytes = 2'd2;
               end
               finished_in  = third_pad_ff || is_pad;
               acc_in       = '0;
               count_in     = '0;
               third_pad_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         third_pad_ff <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         third_pad_ff <= third_pad_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

FILE: sv/b64d_queue.sv
// Short record queue between the front end and the byte emitter.
module b64d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output b64d_pkg::entry_type head
);
   import b64d_pkg::*;

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/b64d_back.sv
// Back end: walks each queued record and emits one result transaction per cycle while rsp_if is ready.
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  b64d_pkg::entry_type head,
   output logic                pop,
   b64d_rsp_if.source          rsp_if
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   kind_type   kind_ff, kind_in;
   logic       last_ff, last_in;

   logic       load;
   logic       is_last;
   logic [7:0] sel_byte;

   assign load = !queue_empty && (!valid_ff || rsp_if.ready);

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.bytes[23:16];
         2'd1:    sel_byte = head.bytes[15:8];
         default: sel_byte = head.bytes[7:0];
      endcase
   end

   assign is_last = head.is_end || (idx_ff == head.nbytes - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head.is_end ? 8'd0 : sel_byte;
         kind_in  = head.is_end ? head.end_kind : KIND_DATA;
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.out_byte = byte_ff;
   assign rsp_if.kind     = kind_ff;
   assign rsp_if.last     = last_ff;

endmodule

FILE: dv/b64_decode_checker.sv
// Checker for the Base64 stream decoder: predicts decoded results and compares them.
module b64_decode_checker (
   input  logic clock,
   input  logic reset,
   b64d_req_if  req_if,
   b64d_rsp_if  rsp_if,
   output int   fail_count,
   output int   pending_count,
   output int   results_checked
);
   import b64d_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } decoded_t;

   decoded_t    decoded_q[$];
   logic [17:0] group_bits;
   logic [1:0]  symbols_held;
   logic        third_pad;
   logic        stream_done;

   // Sextet of an alphabet character or '=', -1 for anything else.
   function automatic int symbol_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == CHAR_PLUS) return int'(SEXTET_PLUS);
      if (c == CHAR_SLASH) return int'(SEXTET_SLASH);
      if (c == CHAR_PAD) return 0;
      return -1;
   endfunction

   task automatic clear_group();
      group_bits   = '0;
      symbols_held = '0;
      third_pad    = 1'b0;
   endtask

   task automatic decode_item(input logic is_end, input logic [7:0] ch);
      int          v;
      int          nbytes;
      logic [23:0] whole;
      decoded_t    r;
      if (is_end) begin
         r.out_byte = '0;
         r.kind     = (symbols_held != '0 && !stream_done) ? KIND_TRUNC : KIND_CLEAN;
         r.last     = 1'b1;
         decoded_q.push_back(r);
         clear_group();
         stream_done = 1'b0;
         return;
      end
      if (stream_done) return;
      v = symbol_value(ch);
      if (v < 0) return;
      if (symbols_held != 2'd3) begin
         if (symbols_held == 2'd2 && ch == CHAR_PAD) third_pad = 1'b1;
         group_bits   = {group_bits[11:0], 6'(v)};
         symbols_held = symbols_held + 2'd1;
         return;
      end
      whole  = {group_bits, 6'(v)};
      nbytes = 3;
      if (ch == CHAR_PAD) begin
         nbytes      = 2;
         stream_done = 1'b1;
      end
      if (third_pad) begin
         nbytes      = 1;
         stream_done = 1'b1;
      end
      for (int k = 0; k < nbytes; k++) begin
         r.out_byte = whole[23 - 8 * k -: 8];
         r.kind     = KIND_DATA;
         r.last     = (k == nbytes - 1);
         decoded_q.push_back(r);
      end
      clear_group();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_group();
         stream_done = 1'b0;
         decoded_q.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result: out_byte %0h kind %0d last %0b",
                      rsp_if.out_byte, rsp_if.kind, rsp_if.last);
               fail_count++;
            end else begin
               decoded_t e;
               e = decoded_q.pop_front();
               results_checked++;
               if (rsp_if.out_byte !== e.out_byte) begin
                  $error("out_byte: expected %0h, actual %0h", e.out_byte, rsp_if.out_byte);
                  fail_count++;
               end
               if (rsp_if.kind !== e.kind) begin
                  $error("kind: expected %0d, actual %0d", e.kind, rsp_if.kind);
                  fail_count++;
               end
               if (rsp_if.last !== e.last) begin
                  $error("last: expected %0b, actual %0b", e.last, rsp_if.last);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) decode_item(req_if.cmd, req_if.char_in);
      end
      pending_count = decoded_q.size();
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the Base64 stream decoder: clock, reset, stimulus and verdict.
module tb_top;
   import b64d_pkg::*;

   localparam logic CMD_CHAR   = 1'b0;
   localparam logic CMD_END    = 1'b1;
   localparam int   HOLD_CYCLES = 80;
   localparam int   PHASE_ITEMS = 60;
   localparam int   DRAIN_LIMIT = 20000;
   localparam int   TAIL_NONE    = 0;
   localparam int   TAIL_ONE_PAD = 1;
   localparam int   TAIL_TWO_PAD = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_req;
   int   items_sent;
   int   streams_sent;
   int   fail_count;
   int   pending_count;
   int   results_checked;

   b64d_req_if req_if ();
   b64d_rsp_if rsp_if ();

   base64_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   b64_decode_checker decode_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: random ready at the falling edge; on request, hold ready low
   // for a long stretch so the record queue fills and the input stalls.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] b64_char(input int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
   endfunction

   // Whitespace and punctuation that the decoder must drop.
   function automatic logic [7:0] junk_char();
      case ($urandom_range(5))
         0: return 8'h20;
         1: return 8'h0A;
         2: return 8'h0D;
         3: return 8'h09;
         4: return 8'h2D;
         default: return 8'h2E;
      endcase
   endfunction

   // Offer one transaction after a random idle gap; return at the falling edge
   // that follows its acceptance.
   task automatic send_item(input logic cmd, input logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.char_in <= ch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_symbol(input int v);
      if ($urandom_range(9) == 0) send_item(CMD_CHAR, junk_char());
      send_item(CMD_CHAR, b64_char(v));
   endtask

   task automatic send_end();
      send_item(CMD_END, 8'($urandom_range(255)));
      streams_sent++;
   endtask

   // One random stream: mostly well-formed groups with optional padding, the
   // rest raw noise, truncated groups and misplaced padding.
   task automatic send_stream();
      int pick;
      int tail;
      pick = $urandom_range(9);
      if (pick < 7) begin
         repeat (4 * $urandom_range(3)) send_symbol($urandom_range(63));
         tail = $urandom_range(2);
         case (tail)
            TAIL_TWO_PAD: begin
               repeat (2) send_symbol($urandom_range(63));
               repeat (2) send_item(CMD_CHAR, CHAR_PAD);
            end
            TAIL_ONE_PAD: begin
               repeat (3) send_symbol($urandom_range(63));
               send_item(CMD_CHAR, CHAR_PAD);
            end
            default: ;
         endcase
         // Characters after a padded group must be ignored.
         if (tail != TAIL_NONE && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_item(CMD_CHAR, 8'($urandom_range(255)));
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 8)) send_item(CMD_CHAR, 8'($urandom_range(255)));
      end else if (pick == 8) begin
         repeat (4 * $urandom_range(2)) send_symbol($urandom_range(63));
         repeat ($urandom_range(1, 3)) send_symbol($urandom_range(63));
      end else begin
         repeat ($urandom_range(4, 8)) begin
            if ($urandom_range(4) < 2) send_item(CMD_CHAR, CHAR_PAD);
            else send_symbol($urandom_range(63));
         end
      end
      send_end();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(CMD_CHAR, s[i]);
   endtask

   initial begin
      int waited;
      send_idle_pct  = 23;
      recv_idle_pct  = 54;
      hold_req       = 1'b0;
      req_if.valid   = 1'b0;
      req_if.cmd     = CMD_CHAR;
      req_if.char_in = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: end on an empty stream, alphabet extremes with a pad in
      // second place, dropped bytes, third-place padding, input after a
      // finished stream, leading padding and a truncated group.
      send_item(CMD_END, 8'hFF);
      send_text("A=z0");
      send_item(CMD_CHAR, 8'h00);
      send_text("aZ9+");
      send_item(CMD_CHAR, 8'hFF);
      send_text("//==");
      send_text("Q");
      send_item(CMD_END, 8'h00);
      send_text("=A=B");
      send_item(CMD_END, 8'h5A);
      send_text("ab");
      send_item(CMD_END, 8'hA5);
      streams_sent += 4;

      // Random: three idle mixes, a long receiver hold-off in the last one.
      for (int phase = 0; phase < 3; phase++) begin
         int target;
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_req      = 1'b1;
            end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_stream();
      end
      req_if.valid <= 1'b0;

      // Drain outstanding results, then keep watching for stray results.
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (pending_count != 0)
         $error("%0d expected results never arrived", pending_count);

      $display("Summary: %0d transactions in %0d streams, %0d decoded results compared.",
               items_sent, streams_sent, results_checked);
      $display("Summary: three idle mixes plus a %0d-cycle receiver hold-off.", HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
